// ===== hw/rtl/iet_pkg.sv =====
`default_nettype none

package iet_pkg;

    // table geometry and field widths
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int OWNER_W = 8;
    localparam int OBJECT_W = 16;
    localparam int KEY_W = OWNER_W + OBJECT_W;
    localparam int ITER_W = 32;
    localparam int THR_W = 16;
    localparam int CNT_W = 7;
    localparam int STATUS_W = 3;

    // small queue depths
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    typedef enum logic {
        KIND_MARK = 1'b0,
        KIND_SCAN = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_UPDATED   = 3'd1,
        STAT_UNCHANGED = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_SUGGEST   = 3'd4,
        STAT_NONE      = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_RESOLVE,
        S_MARK_RD,
        S_SCAN_RD,
        S_SCAN_EVAL,
        S_SCAN_END
    } t_state;

    // classified command handed from front to back
    typedef struct packed {
        t_kind              kind;
        logic [KEY_W-1:0]   key;
        logic [ITER_W-1:0]  iteration;
    } t_cmd;

    // one slot of the table memory
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [ITER_W-1:0]  last_use;
    } t_slot;

    // one result beat
    typedef struct packed {
        t_status              status;
        logic [OWNER_W-1:0]   owner;
        logic [OBJECT_W-1:0]  object;
        logic [ITER_W-1:0]    last_use;
        logic [CNT_W-1:0]     run_count;
        logic                 is_last;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/idle_entry_tracker_top.sv =====
`default_nettype none

// Idle entry tracker. Keeps up to TABLE_ENTRIES (owner id, object id) keys with
// the last iteration each was used in. A mark beat (kind 0) gives one result:
// inserted, updated, unchanged or table full. A scan beat (kind 1) gives one
// suggestion per valid slot whose idle span (iteration minus last use, signed)
// reaches the idle threshold, in slot order, the last one flagged with is_last
// and run_count; or a single none-idle result. A mark steps the table engine
// through command take, key match, then slot select and write on a miss, and
// on a hit also the update after the slot memory read. A scan visits every
// slot, and each valid slot a second time for its evaluation, as the slot
// memory has a single read port. A two-beat command queue and a four-beat result
// queue decouple the ports from the table engine. The threshold register is
// written through the cfg channel, which is always ready.
module idle_entry_tracker_top
    import iet_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 i_kind,
    input  wire logic [OWNER_W-1:0]   i_owner_id,
    input  wire logic [OBJECT_W-1:0]  i_object_id,
    input  wire logic [ITER_W-1:0]    i_iteration,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [STATUS_W-1:0]       o_status,
    output logic [OWNER_W-1:0]        o_found_owner,
    output logic [OBJECT_W-1:0]       o_found_object,
    output logic [ITER_W-1:0]         o_last_use,
    output logic [CNT_W-1:0]          o_run_count,
    output logic                      o_is_last,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [THR_W-1:0]     i_cfg_data
);

    logic [THR_W-1:0] r_threshold;
    logic             cmd_valid;
    t_cmd             cmd;
    logic             cmd_ready;
    logic             res_push;
    t_result          res_in;
    logic             res_full;
    t_result          res_out;

    // threshold register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_W'(4);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_threshold <= i_cfg_data;
        end
    end

    iet_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_kind      (i_kind),
        .i_owner_id  (i_owner_id),
        .i_object_id (i_object_id),
        .i_iteration (i_iteration),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    iet_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    iet_result_fifo u_res (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .empty   (empty),
        .pop     (pop),
        .o_data  (res_out)
    );

    // result fields
    assign o_status = res_out.status;
    assign o_found_owner = res_out.owner;
    assign o_found_object = res_out.object;
    assign o_last_use = res_out.last_use;
    assign o_run_count = res_out.run_count;
    assign o_is_last = res_out.is_last;

endmodule

`default_nettype wire

// ===== hw/rtl/iet_front.sv =====
`default_nettype none

module iet_front
    import iet_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 i_kind,
    input  wire logic [OWNER_W-1:0]   i_owner_id,
    input  wire logic [OBJECT_W-1:0]  i_object_id,
    input  wire logic [ITER_W-1:0]    i_iteration,
    output logic                      o_cmd_valid,
    output t_cmd                      o_cmd,
    input  wire logic                 i_cmd_ready
);

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_FW = $clog2(CMD_DEPTH + 1);

    t_cmd              r_buf [CMD_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_FW-1:0] r_cnt;
    t_cmd              cmd_in;
    logic              wr;
    logic              rd;

    // classify the incoming beat
    always_comb begin
        cmd_in.kind = t_kind'(i_kind);
        cmd_in.iteration = i_iteration;
        unique case (t_kind'(i_kind))
            KIND_MARK: cmd_in.key = {i_owner_id, i_object_id};
            KIND_SCAN: cmd_in.key = '0;
            default:   cmd_in.key = '0;
        endcase
    end

    assign full = (r_cnt == CNT_FW'(CMD_DEPTH));
    assign wr = push && !full;
    assign o_cmd_valid = (r_cnt != '0);
    assign rd = o_cmd_valid && i_cmd_ready;
    assign o_cmd = r_buf[r_rptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_buf[r_wptr] <= cmd_in;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wptr <= (r_wptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (rd) begin
                r_rptr <= (r_rptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            unique case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + CNT_FW'(1);
                2'b01:   r_cnt <= r_cnt - CNT_FW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/iet_result_fifo.sv =====
`default_nettype none

module iet_result_fifo
    import iet_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_result  i_data,
    output logic          o_full,
    output logic          empty,
    input  wire logic     pop,
    output t_result       o_data
);

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_FW = $clog2(RES_DEPTH + 1);

    t_result           r_buf [RES_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_FW-1:0] r_cnt;
    logic              wr;
    logic              rd;

    assign o_full = (r_cnt == CNT_FW'(RES_DEPTH));
    assign empty = (r_cnt == '0);
    assign wr = i_push && !o_full;
    assign rd = pop && !empty;
    assign o_data = r_buf[r_rptr];

    // result storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_buf[r_wptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wptr <= (r_wptr == PTR_W'(RES_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (rd) begin
                r_rptr <= (r_rptr == PTR_W'(RES_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            unique case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + CNT_FW'(1);
                2'b01:   r_cnt <= r_cnt - CNT_FW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/iet_back.sv =====
`default_nettype none

module iet_back
    import iet_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [THR_W-1:0]   i_threshold,
    input  wire logic               i_cmd_valid,
    input  wire t_cmd               i_cmd,
    output logic                    o_cmd_ready,
    output logic                    o_res_push,
    output t_result                 o_res,
    input  wire logic               i_res_full
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    t_state                    r_state;
    t_state                    n_state;
    t_cmd                      r_cmd;
    logic [TABLE_ENTRIES-1:0]  r_valid;
    logic [KEY_W-1:0]          r_key [TABLE_ENTRIES];
    t_slot                     r_mem [TABLE_ENTRIES];
    t_slot                     r_rd;
    logic [TABLE_ENTRIES-1:0]  r_hit_vec;
    logic [TABLE_ENTRIES-1:0]  r_free_vec;
    logic [IDX_W-1:0]          r_idx;
    t_slot                     r_pend;
    logic                      r_pend_vld;
    logic [CNT_W-1:0]          r_count;

    logic                      hit;
    logic                      any_free;
    logic [IDX_W-1:0]          hit_idx;
    logic [IDX_W-1:0]          free_idx;
    logic [ITER_W:0]           span;
    logic                      qual;
    logic                      at_last;
    logic                      eval_step;
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    t_slot                     mem_wdata;
    logic [IDX_W-1:0]          rd_addr;
    logic                      ins;
    logic                      take_pend;

    // hit index from the one-hot match vector, lowest free slot
    always_comb begin
        hit_idx = '0;
        free_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (r_hit_vec[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_free_vec[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign hit = |r_hit_vec;
    assign any_free = |r_free_vec;

    // idle span test: signed difference, never qualifies when negative
    assign span = {1'b0, r_cmd.iteration} - {1'b0, r_rd.last_use};
    assign qual = !span[ITER_W] && (span[ITER_W-1:0] >= ITER_W'(i_threshold));
    assign at_last = (r_idx == LAST_IDX);
    assign eval_step = !qual || !(r_pend_vld && i_res_full);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd.kind == KIND_SCAN) ? S_SCAN_RD : S_LOOKUP;
                end
            end
            S_LOOKUP: n_state = S_RESOLVE;
            S_RESOLVE: begin
                if (hit) begin
                    n_state = S_MARK_RD;
                end else if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            S_MARK_RD: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                if (r_valid[r_idx]) begin
                    n_state = S_SCAN_EVAL;
                end else if (at_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_EVAL: begin
                if (eval_step) begin
                    n_state = at_last ? S_SCAN_END : S_SCAN_RD;
                end
            end
            S_SCAN_END: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        o_cmd_ready = 1'b0;
        o_res_push = 1'b0;
        o_res = '0;
        o_res.owner = r_cmd.key[KEY_W-1:OBJECT_W];
        o_res.object = r_cmd.key[OBJECT_W-1:0];
        o_res.is_last = 1'b1;
        mem_we = 1'b0;
        mem_waddr = r_idx;
        mem_wdata.key = r_cmd.key;
        mem_wdata.last_use = r_cmd.iteration;
        rd_addr = r_idx;
        ins = 1'b0;
        take_pend = 1'b0;
        unique case (r_state)
            S_IDLE: o_cmd_ready = 1'b1;
            S_LOOKUP: begin
            end
            S_RESOLVE: begin
                rd_addr = hit_idx;
                if (!hit && !i_res_full) begin
                    o_res_push = 1'b1;
                    if (any_free) begin
                        o_res.status = STAT_INSERTED;
                        o_res.last_use = r_cmd.iteration;
                        ins = 1'b1;
                        mem_we = 1'b1;
                        mem_waddr = free_idx;
                    end else begin
                        o_res.status = STAT_FULL;
                    end
                end
            end
            S_MARK_RD: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_rd.last_use < r_cmd.iteration) begin
                        o_res.status = STAT_UPDATED;
                        o_res.last_use = r_cmd.iteration;
                        mem_we = 1'b1;
                    end else begin
                        o_res.status = STAT_UNCHANGED;
                        o_res.last_use = r_rd.last_use;
                    end
                end
            end
            S_SCAN_RD: begin
            end
            S_SCAN_EVAL: begin
                // a new qualifier releases the one held before it
                o_res.status = STAT_SUGGEST;
                o_res.owner = r_pend.key[KEY_W-1:OBJECT_W];
                o_res.object = r_pend.key[OBJECT_W-1:0];
                o_res.last_use = r_pend.last_use;
                o_res.is_last = 1'b0;
                if (qual && eval_step) begin
                    take_pend = 1'b1;
                    o_res_push = r_pend_vld;
                end
            end
            S_SCAN_END: begin
                o_res_push = !i_res_full;
                if (r_pend_vld) begin
                    o_res.status = STAT_SUGGEST;
                    o_res.owner = r_pend.key[KEY_W-1:OBJECT_W];
                    o_res.object = r_pend.key[OBJECT_W-1:0];
                    o_res.last_use = r_pend.last_use;
                    o_res.run_count = r_count;
                end else begin
                    o_res.status = STAT_NONE;
                    o_res.owner = '0;
                    o_res.object = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[rd_addr];
    end

    // key match cells
    always_ff @(posedge i_clk) begin
        if (ins) begin
            r_key[free_idx] <= r_cmd.key;
        end
        if (r_state == S_LOOKUP) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_hit_vec[i] <= r_valid[i] && (r_key[i] == r_cmd.key);
            end
            r_free_vec <= ~r_valid;
        end
    end

    // payload held across the command
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid) begin
            r_cmd <= i_cmd;
        end
        if (take_pend) begin
            r_pend <= r_rd;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_idx <= '0;
            r_pend_vld <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (ins) begin
                r_valid[free_idx] <= 1'b1;
            end
            if (r_state == S_IDLE && i_cmd_valid) begin
                r_idx <= '0;
                r_pend_vld <= 1'b0;
                r_count <= '0;
            end
            if (r_state == S_RESOLVE && hit) begin
                r_idx <= hit_idx;
            end
            if (r_state == S_SCAN_RD && !r_valid[r_idx] && !at_last) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (r_state == S_SCAN_EVAL && eval_step && !at_last) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (take_pend) begin
                r_pend_vld <= 1'b1;
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire
